// ===== rtl/aooc_pkg.sv =====
`default_nettype none

package aooc_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_DYN_LOAD   = 8'd0;
  localparam logic [7:0] REG_FRAME_SIZE = 8'd1;
  localparam logic [7:0] REG_SB_BIAS    = 8'd2;
  localparam logic [7:0] REG_DATA_BASE  = 8'd3;

  // Operand kinds
  localparam logic [3:0] KIND_CONST       = 4'd0;
  localparam logic [3:0] KIND_CONST_REG   = 4'd1;
  localparam logic [3:0] KIND_MEM_REG     = 4'd2;
  localparam logic [3:0] KIND_MEM_EXTERN  = 4'd3;
  localparam logic [3:0] KIND_MEM_LOCAL   = 4'd4;
  localparam logic [3:0] KIND_MEM_PARAM   = 4'd5;
  localparam logic [3:0] KIND_ADDR_EXTERN = 4'd6;
  localparam logic [3:0] KIND_ADDR_LOCAL  = 4'd7;
  localparam logic [3:0] KIND_ADDR_PARAM  = 4'd8;

  // Operand classes
  localparam logic [4:0] CLS_RCON   = 5'd0;
  localparam logic [4:0] CLS_NCON   = 5'd1;
  localparam logic [4:0] CLS_LCON   = 5'd2;
  localparam logic [4:0] CLS_RACON  = 5'd3;
  localparam logic [4:0] CLS_LACON  = 5'd4;
  localparam logic [4:0] CLS_HOREG  = 5'd5;
  localparam logic [4:0] CLS_ROREG  = 5'd9;
  localparam logic [4:0] CLS_SROREG = 5'd10;
  localparam logic [4:0] CLS_LOREG  = 5'd11;
  localparam logic [4:0] CLS_ADDR   = 5'd12;
  localparam logic [4:0] CLS_HEXT   = 5'd13;
  localparam logic [4:0] CLS_HAUTO  = 5'd18;
  localparam logic [4:0] CLS_RECON  = 5'd23;

  localparam logic [31:0] PARAM_SLOT_SKIP = 32'd4;

  // Stage 1: operand plus the two first-level sums
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] off;
    logic        text;
    logic [31:0] sym_sum;    // symbol + offset
    logic [31:0] frame_sum;  // frame size + offset
  } s1_t;

  // Stage 2: all candidate effective offsets
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] off;
    logic [31:0] sym_sum;
    logic [31:0] sb_rel;     // symbol + offset - bias
    logic [31:0] abs_all;    // symbol + offset + data base
    logic [31:0] abs_data;   // data base added only for data symbols
    logic [31:0] frame_sum;
    logic [31:0] param_sum;  // frame size + offset + slot skip
    logic        text;
  } s2_t;

  // Stage 3: chosen offset and the decisions class selection needs
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] v;
    logic        dyn;
    logic        recon;
  } s3_t;

  // Rotated immediate encoding, zero when no even rotation fits in 8 bits
  function automatic logic [25:0] rot_imm(input logic [31:0] v);
    logic [63:0] dbl;
    logic [31:0] x;
    logic [25:0] res;
    res = '0;
    for (int r = 15; r >= 0; r--) begin
      dbl = {v, v} << (2 * r);
      x   = dbl[63:32];
      if (x[31:8] == 24'd0) begin
        res = {1'b1, 13'd0, 4'(r), x[7:0]};
      end
    end
    return res;
  endfunction

  function automatic logic half_ok(input logic [31:0] v);
    return (v <= 32'h0000_00ff) || (v >= 32'hffff_ff01);
  endfunction

  // Memory class; base picks the register, external or auto group
  function automatic logic [4:0] mem_class(input logic [31:0] v,
                                           input logic [4:0]  base,
                                           input logic        reg_form,
                                           input logic        rot_ok);
    logic        lo;
    logic        hi;
    logic [31:0] neg;
    logic [11:0] mag;
    logic [4:0]  cls;
    lo  = (v <= 32'h0000_0fff);
    hi  = (v >= 32'hffff_f001);
    neg = 32'd0 - v;
    mag = lo ? v[11:0] : neg[11:0];
    if (lo || hi) begin
      if ((mag & 12'hc03) == 12'd0) begin
        cls = half_ok(v) ? base + 5'd2 : base + 5'd1;
      end else if (half_ok(v)) begin
        cls = base;
      end else if (reg_form && rot_ok) begin
        cls = CLS_SROREG;
      end else begin
        cls = base + 5'd3;
      end
    end else if (reg_form) begin
      cls = rot_ok ? CLS_ROREG : CLS_LOREG;
    end else begin
      cls = base + 5'd4;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aooc_addr.sv =====
`default_nettype none

module aooc_addr import aooc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [3:0]  kind_i,
  input  wire logic [31:0] offset_i,
  input  wire logic [31:0] symbol_value_i,
  input  wire logic        symbol_in_text_i,
  input  wire logic [30:0] frame_size_i,
  input  wire logic [31:0] sb_bias_i,
  input  wire logic [31:0] data_base_i,
  output logic             valid_o,
  output s2_t              s2_o
);

  logic v1_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;

  always_comb begin
    s1_d.kind      = kind_i;
    s1_d.off       = offset_i;
    s1_d.text      = symbol_in_text_i;
    s1_d.sym_sum   = symbol_value_i + offset_i;
    s1_d.frame_sum = {1'b0, frame_size_i} + offset_i;
  end

  always_comb begin
    s2_d.kind      = s1_q.kind;
    s2_d.off       = s1_q.off;
    s2_d.text      = s1_q.text;
    s2_d.sym_sum   = s1_q.sym_sum;
    s2_d.sb_rel    = s1_q.sym_sum - sb_bias_i;
    s2_d.abs_all   = s1_q.sym_sum + data_base_i;
    s2_d.abs_data  = s1_q.sym_sum + (s1_q.text ? 32'd0 : data_base_i);
    s2_d.frame_sum = s1_q.frame_sum;
    s2_d.param_sum = s1_q.frame_sum + PARAM_SLOT_SKIP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign s2_o = s2_q;

endmodule

`default_nettype wire

// ===== rtl/aooc_sel.sv =====
`default_nettype none

module aooc_sel import aooc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire s2_t  s2_i,
  input  wire logic dyn_i,
  output logic      valid_o,
  output s3_t       s3_o
);

  s3_t  s3_d, s3_q;
  logic rel_ok;

  // static-base-relative form is only usable when nonzero and encodable
  assign rel_ok = (s2_i.sb_rel != 32'd0) && (rot_imm(s2_i.sb_rel) != 26'd0);

  always_comb begin
    s3_d.kind  = s2_i.kind;
    s3_d.dyn   = dyn_i;
    s3_d.recon = 1'b0;
    case (s2_i.kind)
      KIND_CONST, KIND_CONST_REG, KIND_MEM_REG: s3_d.v = s2_i.off;
      KIND_MEM_EXTERN: s3_d.v = dyn_i ? s2_i.abs_data : s2_i.sb_rel;
      KIND_MEM_LOCAL, KIND_ADDR_LOCAL: s3_d.v = s2_i.frame_sum;
      KIND_MEM_PARAM, KIND_ADDR_PARAM: s3_d.v = s2_i.param_sum;
      KIND_ADDR_EXTERN: begin
        if (s2_i.text) begin
          s3_d.v = s2_i.sym_sum;
        end else if (dyn_i) begin
          s3_d.v = s2_i.abs_all;
        end else if (rel_ok) begin
          s3_d.v     = s2_i.sb_rel;
          s3_d.recon = 1'b1;
        end else begin
          s3_d.v = s2_i.abs_all;
        end
      end
      default: s3_d.v = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  assign s3_o = s3_q;

endmodule

`default_nettype wire

// ===== rtl/aooc_class.sv =====
`default_nettype none

module aooc_class import aooc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire s3_t    s3_i,
  output logic        valid_o,
  output logic [4:0]  cls_o,
  output logic [31:0] v_o,
  output logic [25:0] rot_o
);

  logic [25:0] rot_v;
  logic        rot_ok;
  logic        rot_neg_ok;
  logic [4:0]  cls_d, cls_q;
  logic [31:0] v_q;
  logic [25:0] rot_q;

  assign rot_v      = rot_imm(s3_i.v);
  assign rot_ok     = (rot_v != 26'd0);
  assign rot_neg_ok = (rot_imm(~s3_i.v) != 26'd0);

  always_comb begin
    case (s3_i.kind)
      KIND_CONST: begin
        if (rot_ok) begin
          cls_d = CLS_RCON;
        end else if (rot_neg_ok) begin
          cls_d = CLS_NCON;
        end else begin
          cls_d = CLS_LCON;
        end
      end
      KIND_CONST_REG, KIND_ADDR_LOCAL, KIND_ADDR_PARAM:
        cls_d = rot_ok ? CLS_RACON : CLS_LACON;
      KIND_MEM_REG: cls_d = mem_class(s3_i.v, CLS_HOREG, 1'b1, rot_ok);
      KIND_MEM_EXTERN:
        cls_d = s3_i.dyn ? CLS_ADDR : mem_class(s3_i.v, CLS_HEXT, 1'b0, rot_ok);
      KIND_MEM_LOCAL, KIND_MEM_PARAM:
        cls_d = mem_class(s3_i.v, CLS_HAUTO, 1'b0, rot_ok);
      KIND_ADDR_EXTERN: cls_d = s3_i.recon ? CLS_RECON : CLS_LCON;
      default: cls_d = CLS_LCON;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    v_q   <= s3_i.v;
    rot_q <= rot_v;
  end

  assign cls_o = cls_q;
  assign v_o   = v_q;
  assign rot_o = rot_q;

endmodule

`default_nettype wire

// ===== rtl/arm_operand_offset_classifier_top.sv =====
`default_nettype none

// ARM operand offset classifier. Pulse start with an operand descriptor and,
// after the register stages below, done_o is high for one cycle with the operand
// class, the 32-bit wrapped effective offset and its rotated-immediate
// encoding. The block takes a new transaction every cycle (busy is always
// low); each transaction passes through four register stages: two adder levels, offset
// selection, then the rotation and range checks with the output register.
// Results cannot be held off: the receiver must take done_o as it comes.
// Configuration registers are always ready; the user must see that they are
// written only while no transaction is in flight; the block does not enforce it.
module arm_operand_offset_classifier_top import aooc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         kind_i,
  input  wire logic signed [31:0] offset_i,
  input  wire logic [31:0]        symbol_value_i,
  input  wire logic               symbol_in_text_i,
  output logic                    done_o,
  output logic [4:0]              opnd_cls_o,
  output logic signed [31:0]      resolved_offset_o,
  output logic [25:0]             rotated_immediate_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic        dyn_q;
  logic [30:0] frame_q;
  logic [31:0] bias_q;
  logic [31:0] dbase_q;
  logic        accept;
  logic        v2;
  logic        v3;
  s2_t         s2;
  s3_t         s3;
  logic [31:0] v_out;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_q   <= 1'b0;
      frame_q <= '0;
      bias_q  <= '0;
      dbase_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DYN_LOAD:   dyn_q   <= cfg_data_i[0];
        REG_FRAME_SIZE: frame_q <= cfg_data_i[30:0];
        REG_SB_BIAS:    bias_q  <= cfg_data_i;
        REG_DATA_BASE:  dbase_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aooc_addr u_addr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (accept),
    .kind_i           (kind_i),
    .offset_i         (offset_i),
    .symbol_value_i   (symbol_value_i),
    .symbol_in_text_i (symbol_in_text_i),
    .frame_size_i     (frame_q),
    .sb_bias_i        (bias_q),
    .data_base_i      (dbase_q),
    .valid_o          (v2),
    .s2_o             (s2)
  );

  aooc_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .s2_i    (s2),
    .dyn_i   (dyn_q),
    .valid_o (v3),
    .s3_o    (s3)
  );

  aooc_class u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .s3_i    (s3),
    .valid_o (done_o),
    .cls_o   (opnd_cls_o),
    .v_o     (v_out),
    .rot_o   (rotated_immediate_o)
  );

  assign resolved_offset_o = v_out;

  // one result per accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4))
      |-> (done_o == $past(accept, 4)))
    else $error("done_o does not match accepted transaction");

  // base-relative form is chosen only for a nonzero encodable offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && opnd_cls_o == CLS_RECON)
      |-> (resolved_offset_o != 32'sd0 && rotated_immediate_o != 26'd0))
    else $error("RECON class with unencodable offset");

  // rotated-constant classes must carry an encoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (opnd_cls_o == CLS_RCON || opnd_cls_o == CLS_RACON))
      |-> (rotated_immediate_o != 26'd0))
    else $error("rotated constant class without encoding");

endmodule

`default_nettype wire

// ===== test/tb_arm_operand_offset_classifier_top.sv =====
`default_nettype none

module tb_arm_operand_offset_classifier_top;
  import aooc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int NUM_PHASES      = 4;
  localparam int NUM_DIR_ROWS    = 25;

  // Kind codes the block does not define
  localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  // Offsets inside a memory class group: H, F, HF, S, L
  localparam logic [4:0] GRP_FLOAT      = 5'd1;
  localparam logic [4:0] GRP_HALF_FLOAT = 5'd2;
  localparam logic [4:0] GRP_SHORT      = 5'd3;
  localparam logic [4:0] GRP_LONG       = 5'd4;

  typedef struct packed {
    logic [4:0]  cls;
    logic [31:0] off;
    logic [25:0] imm;
  } operand_res_t;

  typedef struct packed {
    logic [3:0]   kind;
    logic [31:0]  off;
    logic [31:0]  sym;
    logic         text;
    logic         typed;
    operand_res_t res;
  } dir_row_t;

  // Typed results hold for the reset configuration only
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    '{KIND_CONST,       32'h0000_0000, 32'h0, 1'b0, 1'b1,
      '{CLS_RCON, 32'h0000_0000, 26'h200_0000}},
    '{KIND_CONST,       32'h0000_00ff, 32'h0, 1'b0, 1'b1,
      '{CLS_RCON, 32'h0000_00ff, 26'h200_00ff}},
    '{KIND_CONST,       32'hffff_ffff, 32'h0, 1'b0, 1'b1,
      '{CLS_NCON, 32'hffff_ffff, 26'h0}},
    '{KIND_CONST,       32'h7fff_ffff, 32'h0, 1'b0, 1'b1,
      '{CLS_NCON, 32'h7fff_ffff, 26'h0}},
    '{KIND_CONST,       32'h1234_5678, 32'h0, 1'b0, 1'b1,
      '{CLS_LCON, 32'h1234_5678, 26'h0}},
    '{KIND_CONST,       32'h8000_0000, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_CONST_REG,   32'h0000_00ff, 32'h0, 1'b0, 1'b1,
      '{CLS_RACON, 32'h0000_00ff, 26'h200_00ff}},
    '{KIND_CONST_REG,   32'h1234_5678, 32'h0, 1'b0, 1'b1,
      '{CLS_LACON, 32'h1234_5678, 26'h0}},
    '{KIND_MEM_REG,     32'h0000_0000, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_MEM_REG,     32'h0000_0fff, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_MEM_REG,     32'hffff_f001, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_MEM_REG,     32'hffff_f000, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_MEM_REG,     32'h0000_0400, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_MEM_REG,     32'h0000_1000, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_MEM_REG,     32'h7fff_ffff, 32'h0, 1'b0, 1'b1,
      '{CLS_LOREG, 32'h7fff_ffff, 26'h0}},
    '{KIND_MEM_EXTERN,  32'h0000_0001, 32'hffff_ffff, 1'b0, 1'b0, '0},
    '{KIND_MEM_EXTERN,  32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, '0},
    '{KIND_MEM_LOCAL,   32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b0, '0},
    '{KIND_MEM_PARAM,   32'hffff_fffc, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_ADDR_EXTERN, 32'h0000_0000, 32'h0, 1'b0, 1'b1,
      '{CLS_LCON, 32'h0000_0000, 26'h200_0000}},
    '{KIND_ADDR_EXTERN, 32'h0000_0040, 32'h0000_00c0, 1'b0, 1'b0, '0},
    '{KIND_ADDR_EXTERN, 32'h1234_5678, 32'h0, 1'b1, 1'b1,
      '{CLS_LCON, 32'h1234_5678, 26'h0}},
    '{KIND_ADDR_LOCAL,  32'hffff_fff0, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_ADDR_PARAM,  32'h7fff_fffc, 32'h0, 1'b0, 1'b0, '0},
    '{KIND_UNUSED_HI,   32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, '0}
  };

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               start            = 1'b0;
  logic               busy;
  logic [3:0]         kind_i           = '0;
  logic signed [31:0] offset_i         = '0;
  logic [31:0]        symbol_value_i   = '0;
  logic               symbol_in_text_i = 1'b0;
  logic               done_o;
  logic [4:0]         opnd_cls_o;
  logic signed [31:0] resolved_offset_o;
  logic [25:0]        rotated_immediate_o;
  logic               cfg_valid_i      = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_index_i      = '0;
  logic [31:0]        cfg_data_i       = '0;

  // Typed expectation travels alongside the operand it belongs to
  logic               typed_row        = 1'b0;
  operand_res_t       typed_res        = '0;

  // Shadow of the configuration registers
  logic               dyn_load_q       = 1'b0;
  logic [30:0]        frame_size_q     = '0;
  logic [31:0]        sb_bias_q        = '0;
  logic [31:0]        data_base_q      = '0;

  operand_res_t       expected_results[$];
  int                 error_count      = 0;
  int                 idle_cycles      = 0;
  int                 idle_pct         = 0;

  arm_operand_offset_classifier_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .kind_i              (kind_i),
    .offset_i            (offset_i),
    .symbol_value_i      (symbol_value_i),
    .symbol_in_text_i    (symbol_in_text_i),
    .done_o              (done_o),
    .opnd_cls_o          (opnd_cls_o),
    .resolved_offset_o   (resolved_offset_o),
    .rotated_immediate_o (rotated_immediate_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // First even left rotation that fits in 8 bits, zero when none does
  function automatic logic [25:0] rot_encoding(input logic [31:0] value);
    logic [31:0] x;
    logic [25:0] enc;
    logic        found;
    x     = value;
    enc   = '0;
    found = 1'b0;
    for (int r = 0; r < 16; r++) begin
      if (!found && x[31:8] == 24'd0) begin
        enc   = {1'b1, 13'd0, 4'(r), x[7:0]};
        found = 1'b1;
      end
      x = {x[29:0], x[31:30]};
    end
    return enc;
  endfunction

  function automatic logic halfword_ok(input logic [31:0] v);
    return (v <= 32'h0000_00ff) || (v >= 32'hffff_ff01);
  endfunction

  function automatic logic [4:0] mem_access_class(input logic [31:0] v,
                                                  input logic [4:0]  base,
                                                  input logic        reg_form);
    logic        near_pos;
    logic        near_neg;
    logic [31:0] mag;
    logic [4:0]  cls;
    near_pos = (v <= 32'h0000_0fff);
    near_neg = (v >= 32'hffff_f001);
    mag      = near_pos ? v : 32'd0 - v;
    if (near_pos || near_neg) begin
      // float needs bits 0, 1, 10 and 11 of the magnitude clear
      if ((mag & 32'h0000_0c03) == 32'd0) begin
        cls = halfword_ok(v) ? base + GRP_HALF_FLOAT : base + GRP_FLOAT;
      end else if (halfword_ok(v)) begin
        cls = base;
      end else if (reg_form && rot_encoding(v) != 26'd0) begin
        cls = CLS_SROREG;
      end else begin
        cls = base + GRP_SHORT;
      end
    end else if (reg_form) begin
      cls = (rot_encoding(v) != 26'd0) ? CLS_ROREG : CLS_LOREG;
    end else begin
      cls = base + GRP_LONG;
    end
    return cls;
  endfunction

  function automatic operand_res_t classify_operand(input logic [3:0]  kind,
                                                    input logic [31:0] off,
                                                    input logic [31:0] sym,
                                                    input logic        text);
    logic [31:0]  v;
    logic [31:0]  frame;
    logic [31:0]  sb_rel;
    logic [4:0]   cls;
    operand_res_t res;
    frame = {1'b0, frame_size_q};
    v     = '0;
    cls   = CLS_LCON;
    case (kind)
      KIND_CONST: begin
        v = off;
        if (rot_encoding(v) != 26'd0)       cls = CLS_RCON;
        else if (rot_encoding(~v) != 26'd0) cls = CLS_NCON;
        else                                cls = CLS_LCON;
      end
      KIND_CONST_REG: begin
        v   = off;
        cls = (rot_encoding(v) != 26'd0) ? CLS_RACON : CLS_LACON;
      end
      KIND_MEM_REG: begin
        v   = off;
        cls = mem_access_class(v, CLS_HOREG, 1'b1);
      end
      KIND_MEM_EXTERN: begin
        if (dyn_load_q) begin
          v = sym + off;
          if (!text) v = v + data_base_q;
          cls = CLS_ADDR;
        end else begin
          v   = sym + off - sb_bias_q;
          cls = mem_access_class(v, CLS_HEXT, 1'b0);
        end
      end
      KIND_MEM_LOCAL: begin
        v   = frame + off;
        cls = mem_access_class(v, CLS_HAUTO, 1'b0);
      end
      KIND_MEM_PARAM: begin
        v   = frame + PARAM_SLOT_SKIP + off;
        cls = mem_access_class(v, CLS_HAUTO, 1'b0);
      end
      KIND_ADDR_EXTERN: begin
        if (text) begin
          v = sym + off;
        end else if (dyn_load_q) begin
          v = sym + off + data_base_q;
        end else begin
          // prefer a static base relative constant, fall back to absolute
          sb_rel = sym + off - sb_bias_q;
          if (sb_rel != 32'd0 && rot_encoding(sb_rel) != 26'd0) begin
            v   = sb_rel;
            cls = CLS_RECON;
          end else begin
            v = sym + off + data_base_q;
          end
        end
      end
      KIND_ADDR_LOCAL: begin
        v   = frame + off;
        cls = (rot_encoding(v) != 26'd0) ? CLS_RACON : CLS_LACON;
      end
      KIND_ADDR_PARAM: begin
        v   = frame + off + PARAM_SLOT_SKIP;
        cls = (rot_encoding(v) != 26'd0) ? CLS_RACON : CLS_LACON;
      end
      default: begin
        v   = '0;
        cls = CLS_LCON;
      end
    endcase
    res.cls = cls;
    res.off = v;
    res.imm = rot_encoding(v);
    return res;
  endfunction

  always @(posedge clk_i) begin
    operand_res_t want;
    logic         progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        case (cfg_index_i)
          REG_DYN_LOAD:   dyn_load_q   = cfg_data_i[0];
          REG_FRAME_SIZE: frame_size_q = cfg_data_i[30:0];
          REG_SB_BIAS:    sb_bias_q    = cfg_data_i;
          REG_DATA_BASE:  data_base_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        progress = 1'b1;
        expected_results.push_back(typed_row ? typed_res :
          classify_operand(kind_i, offset_i, symbol_value_i, symbol_in_text_i));
      end
      if (done_o) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: class %0d, offset %h", opnd_cls_o,
                 resolved_offset_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (opnd_cls_o !== want.cls) begin
            $error("opnd_cls: expected %0d, got %0d", want.cls, opnd_cls_o);
            error_count++;
          end
          if (resolved_offset_o !== want.off) begin
            $error("resolved_offset: expected %h, got %h", want.off, resolved_offset_o);
            error_count++;
          end
          if (rotated_immediate_o !== want.imm) begin
            $error("rotated_immediate: expected %h, got %h", want.imm,
                   rotated_immediate_o);
            error_count++;
          end
        end
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_operand(input logic [3:0]   kind,
                              input logic [31:0]  off,
                              input logic [31:0]  sym,
                              input logic         text,
                              input logic         typed,
                              input operand_res_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start            <= 1'b1;
    kind_i           <= kind;
    offset_i         <= off;
    symbol_value_i   <= sym;
    symbol_in_text_i <= text;
    typed_row        <= typed;
    typed_res        <= res;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off new operands until every outstanding transaction has returned
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic        dyn,
                              input logic [31:0] frame,
                              input logic [31:0] bias,
                              input logic [31:0] base);
    logic [7:0]  idx [4];
    logic [31:0] val [4];
    idx = '{REG_DYN_LOAD, REG_FRAME_SIZE, REG_SB_BIAS, REG_DATA_BASE};
    val = '{{31'd0, dyn}, frame, bias, base};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Effective offsets near the encoding boundaries, plus plain noise
  function automatic logic [31:0] pick_target();
    logic [31:0] t;
    logic [63:0] dbl;
    logic [7:0]  b;
    int          rot;
    b   = 8'($urandom_range(0, 255));
    rot = $urandom_range(0, 15);
    dbl = {24'd0, b, 24'd0, b} >> (2 * rot);
    case ($urandom_range(0, 8))
      0: t = $urandom_range(0, 600) - 300;
      1: t = $urandom_range(32'h0000_0f00, 32'h0000_1100);
      2: t = dbl[31:0];
      3: t = ~dbl[31:0];
      4: t = $urandom;
      5: begin
        case ($urandom_range(0, 3))
          0:       t = 32'h8000_0000;
          1:       t = 32'h7fff_ffff;
          2:       t = 32'h0000_0000;
          default: t = 32'hffff_ffff;
        endcase
      end
      6: t = $urandom_range(0, 1023) << 2;
      7: t = $urandom_range(32'h0000_00f0, 32'h0000_0110);
      default: t = dbl[31:0] + $urandom_range(0, 3) - 1;
    endcase
    if ($urandom_range(0, 1) == 1) t = 32'd0 - t;
    return t;
  endfunction

  task automatic run_random(input int count);
    logic [3:0]  kind;
    logic [31:0] sym;
    logic [31:0] off;
    logic [31:0] t;
    logic [31:0] frame;
    logic        text;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 19);
      kind  = (pick < 18) ? 4'(pick % (KIND_ADDR_PARAM + 1))
                          : 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      sym   = $urandom;
      text  = 1'($urandom_range(0, 1));
      t     = pick_target();
      frame = {1'b0, frame_size_q};
      // back-solve the offset so the effective offset lands on the target
      case (kind)
        KIND_CONST, KIND_CONST_REG, KIND_MEM_REG: off = t;
        KIND_MEM_EXTERN:
          off = dyn_load_q ? t - sym - (text ? 32'd0 : data_base_q) : t - sym + sb_bias_q;
        KIND_MEM_LOCAL, KIND_ADDR_LOCAL: off = t - frame;
        KIND_MEM_PARAM, KIND_ADDR_PARAM: off = t - frame - PARAM_SLOT_SKIP;
        KIND_ADDR_EXTERN: begin
          if (text)            off = t - sym;
          else if (dyn_load_q) off = t - sym - data_base_q;
          else                 off = t - sym + sb_bias_q;
        end
        default: off = $urandom;
      endcase
      if ($urandom_range(0, 6) == 0) off = $urandom;
      if ($urandom_range(0, 199) == 0) drain_results();
      send_operand(kind, off, sym, text, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: once at reset configuration, once at the far extremes
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) program_regs(1'b1, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      for (int i = 0; i < NUM_DIR_ROWS; i++) begin
        send_operand(DIR_ROWS[i].kind, DIR_ROWS[i].off, DIR_ROWS[i].sym,
                     DIR_ROWS[i].text, DIR_ROWS[i].typed && pass == 0,
                     DIR_ROWS[i].res);
      end
      drain_results();
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          program_regs(1'b0, $urandom_range(0, 8192), $urandom_range(0, 4096), $urandom);
          idle_pct = 0;
        end
        1: begin
          program_regs(1'b1, $urandom, $urandom, $urandom);
          idle_pct = 62;
        end
        2: begin
          program_regs(1'b0, 32'd0, 32'd0, 32'd0);
          idle_pct = 10;
        end
        default: begin
          // frame size write carries a set top bit, which must be dropped
          program_regs(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
          idle_pct = 62;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== arm_operand_offset_classifier_top.f =====
rtl/aooc_pkg.sv
rtl/aooc_addr.sv
rtl/aooc_sel.sv
rtl/aooc_class.sv
rtl/arm_operand_offset_classifier_top.sv
test/tb_arm_operand_offset_classifier_top.sv
